FILE: rtl/core/clle_pkg.sv
// ----------------------------------------------------------------------------
// clle_pkg
// Shared constants, codes and interface types of the cursor linked list engine.
// ----------------------------------------------------------------------------
package clle_pkg;

  // Pool geometry.
  localparam int NODES  = 16;
  localparam int LISTS  = 4;
  localparam int NODE_W = $clog2(NODES);
  localparam int LIST_W = $clog2(LISTS);
  localparam int STEP_W = $clog2(NODES + 1);

  // Field widths fixed by the transaction format.
  localparam int PTR_W = 5;
  localparam int VAL_W = 8;
  localparam int CMD_W = 3;
  localparam int LID_W = 2;
  localparam int ST_W  = 2;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CMD_W-1:0] cmd_t;
  typedef logic [ST_W-1:0]  stat_t;

  // A link that points nowhere (signed -1).
  localparam ptr_t NIL = '1;

  // Command codes.
  localparam cmd_t CMD_INS_FIRST  = 3'd0;
  localparam cmd_t CMD_INS_SORTED = 3'd1;
  localparam cmd_t CMD_INS_LAST   = 3'd2;
  localparam cmd_t CMD_DEL_FIRST  = 3'd3;
  localparam cmd_t CMD_DEL_ALL    = 3'd4;
  localparam cmd_t CMD_CLEAR      = 3'd5;
  localparam cmd_t CMD_REINIT     = 3'd6;

  // Result status codes.
  localparam stat_t ST_OK      = 2'd0;
  localparam stat_t ST_FULL    = 2'd1;
  localparam stat_t ST_NOMATCH = 2'd2;

  // Strobes from the controller to the datapath.
  typedef struct packed {
    logic latch;       // capture a new command and reset the walk
    logic reinit;      // return pool and heads to their reset values
    logic alloc_rd;    // read the link of the free list head
    logic alloc_ev;    // pop the free list head
    logic rd_cur;      // read the node under the cursor
    logic adv;         // step the cursor past a node that stays
    logic ins_link;    // write value and link of the new node
    logic ins_set;     // hook the new node behind its predecessor
    logic del_unlink;  // bridge the predecessor over the cursor node
    logic del_free;    // push the cursor node on the free list
    logic del_end;     // close a delete walk
    logic finish;      // load the result register
  } ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    cmd_t cmd;       // command being executed
    logic free_ok;   // free list is not empty
    logic walk_ok;   // cursor is on a node and the walk bound is not reached
    logic ge;        // cursor node value is not less than the element
    logic del_hit;   // cursor node is to be removed
    logic out_free;  // result register can take a new result
  } sts_t;

  // True when a link names a node of the pool.
  function automatic logic ptr_valid(input ptr_t p);
    return !p[PTR_W-1];
  endfunction

endpackage

FILE: rtl/core/clle_ram.sv
// ----------------------------------------------------------------------------
// clle_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module clle_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/clle_dp.sv
// ----------------------------------------------------------------------------
// clle_dp
// Datapath: node memories, free list and list heads, walk cursor and the
// result register.
// ----------------------------------------------------------------------------
module clle_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  clle_pkg::ctl_t                ctl,
  input  clle_pkg::cmd_t                in_cmd,
  input  logic [clle_pkg::LID_W-1:0]    in_list_id,
  input  logic signed [clle_pkg::VAL_W-1:0] in_elem,
  input  logic                          out_tready,
  output clle_pkg::sts_t                sts,
  output logic                          out_tvalid,
  output clle_pkg::stat_t               out_status,
  output clle_pkg::ptr_t                out_node_index
);

  localparam int NODES  = clle_pkg::NODES;
  localparam int LISTS  = clle_pkg::LISTS;
  localparam int NODE_W = clle_pkg::NODE_W;
  localparam int LIST_W = clle_pkg::LIST_W;
  localparam int STEP_W = clle_pkg::STEP_W;
  localparam int VAL_W  = clle_pkg::VAL_W;

  // Command context.
  clle_pkg::cmd_t            cmd_r, cmd_nxt;
  logic [LIST_W-1:0]         lst_r, lst_nxt;
  logic signed [VAL_W-1:0]   elem_r, elem_nxt;

  // Walk state.
  clle_pkg::ptr_t            cur_r, cur_nxt;
  clle_pkg::ptr_t            prev_r, prev_nxt;
  clle_pkg::ptr_t            n_r, n_nxt;
  clle_pkg::ptr_t            nx_r, nx_nxt;
  logic [STEP_W-1:0]         steps_r, steps_nxt;
  clle_pkg::ptr_t            idx_r, idx_nxt;
  clle_pkg::stat_t           stat_r, stat_nxt;

  // Pool state.
  clle_pkg::ptr_t            free_head_r, free_head_nxt;
  clle_pkg::ptr_t            head_r [LISTS];
  clle_pkg::ptr_t            head_nxt [LISTS];
  logic [NODES-1:0]          vld_r, vld_nxt;

  // Result register.
  logic                      out_valid_r, out_valid_nxt;
  clle_pkg::stat_t           out_status_r;
  clle_pkg::ptr_t            out_idx_r;

  // Memory ports.
  logic                      link_we, val_we, mem_re;
  logic [NODE_W-1:0]         link_waddr, val_waddr, mem_raddr;
  clle_pkg::ptr_t            link_wdata;
  clle_pkg::ptr_t            link_ram_q;
  logic [VAL_W-1:0]          val_ram_q;
  logic signed [VAL_W-1:0]   val_q;
  logic [NODE_W-1:0]         rd_addr_r;
  clle_pkg::ptr_t            link_q;
  logic                      in_is_ins;

  clle_ram #(.WIDTH(clle_pkg::PTR_W), .DEPTH(NODES)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (link_ram_q)
  );

  clle_ram #(.WIDTH(VAL_W), .DEPTH(NODES)) u_val_ram (
    .clk   (clk),
    .we    (val_we),
    .waddr (val_waddr),
    .wdata (elem_r),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (val_ram_q)
  );

  assign val_q = val_ram_q;

  // A link entry never written since reset or reinit reads as its index minus one.
  assign link_q = vld_r[rd_addr_r] ? link_ram_q
                                   : clle_pkg::ptr_t'({1'b0, rd_addr_r}) - clle_pkg::ptr_t'(1);

  // Read address: the free list head while allocating, else the cursor.
  assign mem_re    = ctl.alloc_rd | ctl.rd_cur;
  assign mem_raddr = ctl.alloc_rd ? free_head_r[NODE_W-1:0] : cur_r[NODE_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_re) begin
      rd_addr_r <= mem_raddr;
    end
  end

  // Link memory write port, one link update per cycle.
  always_comb begin
    link_we    = 1'b0;
    link_waddr = n_r[NODE_W-1:0];
    link_wdata = clle_pkg::ptr_valid(cur_r) ? cur_r : clle_pkg::NIL;
    if (ctl.ins_link) begin
      link_we = 1'b1;
    end else if (ctl.ins_set && clle_pkg::ptr_valid(prev_r)) begin
      link_we    = 1'b1;
      link_waddr = prev_r[NODE_W-1:0];
      link_wdata = n_r;
    end else if (ctl.del_unlink && clle_pkg::ptr_valid(prev_r)) begin
      link_we    = 1'b1;
      link_waddr = prev_r[NODE_W-1:0];
      link_wdata = link_q;
    end else if (ctl.del_free) begin
      link_we    = 1'b1;
      link_waddr = cur_r[NODE_W-1:0];
      link_wdata = free_head_r;
    end
  end

  // Value memory is written only when a node is allocated.
  assign val_we    = ctl.ins_link;
  assign val_waddr = n_r[NODE_W-1:0];

  assign in_is_ins = (in_cmd == clle_pkg::CMD_INS_FIRST) ||
                     (in_cmd == clle_pkg::CMD_INS_SORTED) ||
                     (in_cmd == clle_pkg::CMD_INS_LAST);

  // Next-state logic of the walk, pool and result registers.
  always_comb begin
    cmd_nxt       = cmd_r;
    lst_nxt       = lst_r;
    elem_nxt      = elem_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    n_nxt         = n_r;
    nx_nxt        = nx_r;
    steps_nxt     = steps_r;
    idx_nxt       = idx_r;
    stat_nxt      = stat_r;
    free_head_nxt = free_head_r;
    head_nxt      = head_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;

    if (ctl.latch) begin
      cmd_nxt   = in_cmd;
      lst_nxt   = in_list_id[LIST_W-1:0];
      elem_nxt  = in_elem;
      cur_nxt   = head_r[in_list_id[LIST_W-1:0]];
      prev_nxt  = clle_pkg::NIL;
      steps_nxt = '0;
      idx_nxt   = clle_pkg::NIL;
      stat_nxt  = (in_is_ins && !clle_pkg::ptr_valid(free_head_r)) ? clle_pkg::ST_FULL
                                                                   : clle_pkg::ST_OK;
    end

    if (ctl.alloc_ev) begin
      n_nxt         = free_head_r;
      free_head_nxt = link_q;
      idx_nxt       = free_head_r;
    end

    if (ctl.rd_cur) begin
      steps_nxt = steps_r + STEP_W'(1);
    end

    if (ctl.adv) begin
      prev_nxt = cur_r;
      cur_nxt  = link_q;
    end

    if (ctl.ins_set && !clle_pkg::ptr_valid(prev_r)) begin
      head_nxt[lst_r] = n_r;
    end

    if (ctl.del_unlink) begin
      nx_nxt = link_q;
      if (!clle_pkg::ptr_valid(prev_r)) begin
        head_nxt[lst_r] = link_q;
      end
    end

    if (ctl.del_free) begin
      free_head_nxt = cur_r;
      cur_nxt       = nx_r;
      if (idx_r == clle_pkg::NIL) begin
        idx_nxt = cur_r;
      end
    end

    if (ctl.del_end && idx_r == clle_pkg::NIL && cmd_r != clle_pkg::CMD_CLEAR) begin
      stat_nxt = clle_pkg::ST_NOMATCH;
    end

    // Mark link entries once written.
    if (link_we) begin
      vld_nxt[link_waddr] = 1'b1;
    end

    if (ctl.reinit) begin
      free_head_nxt = clle_pkg::ptr_t'(NODES - 1);
      for (int i = 0; i < LISTS; i++) begin
        head_nxt[i] = clle_pkg::NIL;
      end
      vld_nxt = '0;
    end

    // Result register handshake.
    if (ctl.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  // Control and pool state with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      free_head_r <= clle_pkg::ptr_t'(NODES - 1);
      for (int i = 0; i < LISTS; i++) begin
        head_r[i] <= clle_pkg::NIL;
      end
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      free_head_r <= free_head_nxt;
      head_r      <= head_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Walk and payload registers.
  always_ff @(posedge clk) begin
    cmd_r   <= cmd_nxt;
    lst_r   <= lst_nxt;
    elem_r  <= elem_nxt;
    cur_r   <= cur_nxt;
    prev_r  <= prev_nxt;
    n_r     <= n_nxt;
    nx_r    <= nx_nxt;
    steps_r <= steps_nxt;
    idx_r   <= idx_nxt;
    stat_r  <= stat_nxt;
    if (ctl.finish) begin
      out_status_r <= stat_r;
      out_idx_r    <= idx_r;
    end
  end

  // Status toward the controller.
  always_comb begin
    sts.cmd      = cmd_r;
    sts.free_ok  = clle_pkg::ptr_valid(free_head_r);
    sts.walk_ok  = clle_pkg::ptr_valid(cur_r) && (steps_r < STEP_W'(NODES));
    sts.ge       = (val_q >= elem_r);
    sts.del_hit  = (cmd_r == clle_pkg::CMD_CLEAR) || (val_q == elem_r);
    sts.out_free = !out_valid_r || out_tready;
  end

  assign out_tvalid     = out_valid_r;
  assign out_status     = out_status_r;
  assign out_node_index = out_idx_r;

endmodule

FILE: rtl/core/clle_ctrl.sv
// ----------------------------------------------------------------------------
// clle_ctrl
// Controller: sequences allocation, list walks, link updates and the result
// for one command at a time.
// ----------------------------------------------------------------------------
module clle_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  input  clle_pkg::cmd_t in_cmd,
  input  clle_pkg::sts_t sts,
  output logic           in_tready,
  output clle_pkg::ctl_t ctl
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_ALLOC_RD = 4'd1;
  localparam logic [3:0] S_ALLOC_EV = 4'd2;
  localparam logic [3:0] S_WALK_RD  = 4'd3;
  localparam logic [3:0] S_WALK_EV  = 4'd4;
  localparam logic [3:0] S_INS_LINK = 4'd5;
  localparam logic [3:0] S_INS_SET  = 4'd6;
  localparam logic [3:0] S_DEL_RD   = 4'd7;
  localparam logic [3:0] S_DEL_EV   = 4'd8;
  localparam logic [3:0] S_DEL_FREE = 4'd9;
  localparam logic [3:0] S_DONE     = 4'd10;

  logic [3:0] state_r, state_nxt;
  logic       accept;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;

  // State transitions and datapath strobes.
  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.latch = 1'b1;
          unique case (in_cmd) inside
            clle_pkg::CMD_INS_FIRST, clle_pkg::CMD_INS_SORTED,
            clle_pkg::CMD_INS_LAST: begin
              state_nxt = sts.free_ok ? S_ALLOC_RD : S_DONE;
            end
            clle_pkg::CMD_DEL_FIRST, clle_pkg::CMD_DEL_ALL,
            clle_pkg::CMD_CLEAR: begin
              state_nxt = S_DEL_RD;
            end
            clle_pkg::CMD_REINIT: begin
              ctl.reinit = 1'b1;
              state_nxt  = S_DONE;
            end
            default: begin
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_ALLOC_RD: begin
        ctl.alloc_rd = 1'b1;
        state_nxt    = S_ALLOC_EV;
      end
      S_ALLOC_EV: begin
        ctl.alloc_ev = 1'b1;
        state_nxt    = (sts.cmd == clle_pkg::CMD_INS_FIRST) ? S_INS_LINK : S_WALK_RD;
      end
      S_WALK_RD: begin
        if (sts.walk_ok) begin
          ctl.rd_cur = 1'b1;
          state_nxt  = S_WALK_EV;
        end else begin
          state_nxt = S_INS_LINK;
        end
      end
      S_WALK_EV: begin
        if (sts.cmd == clle_pkg::CMD_INS_SORTED && sts.ge) begin
          state_nxt = S_INS_LINK;
        end else begin
          ctl.adv   = 1'b1;
          state_nxt = S_WALK_RD;
        end
      end
      S_INS_LINK: begin
        ctl.ins_link = 1'b1;
        state_nxt    = S_INS_SET;
      end
      S_INS_SET: begin
        ctl.ins_set = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DEL_RD: begin
        if (sts.walk_ok) begin
          ctl.rd_cur = 1'b1;
          state_nxt  = S_DEL_EV;
        end else begin
          ctl.del_end = 1'b1;
          state_nxt   = S_DONE;
        end
      end
      S_DEL_EV: begin
        if (sts.del_hit) begin
          ctl.del_unlink = 1'b1;
          state_nxt      = S_DEL_FREE;
        end else begin
          ctl.adv   = 1'b1;
          state_nxt = S_DEL_RD;
        end
      end
      S_DEL_FREE: begin
        ctl.del_free = 1'b1;
        state_nxt    = (sts.cmd == clle_pkg::CMD_DEL_FIRST) ? S_DONE : S_DEL_RD;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/core/cursor_linked_list_engine_core.sv
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// Pool of 16 linked nodes shared by 4 lists, with a free list through the
// unused nodes; one command in, one status and node index out.
// ----------------------------------------------------------------------------
// The engine takes one command at a time and returns exactly one result per
// command. Insert at front reads the free list head, pops it, writes the new
// node and hooks it in before the result; reinit, unused codes and an insert
// into a full pool go straight to the result. Sorted and tail inserts walk
// the list node by node (address, then registered read data of the node
// memories); a list holds at most NODES-1 nodes while a node is still free.
// Deletes walk kept nodes the same way; a removed node also needs a free
// step, since the single link memory write port must bridge the predecessor
// and push the freed node in separate steps. Reset and reinit need no
// clearing pass, since link entries carry written flags. A new command is
// taken as soon as the previous result sits in the output register.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core (
  input  logic        clk,
  input  logic        rst_n,
  // Command channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [2:0] cmd, [4:3] list_id, [12:5] elem, [15:13] zero
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [1:0] status, [6:2] node_index, [7] zero
);

  clle_pkg::ctl_t  ctl;
  clle_pkg::sts_t  sts;
  clle_pkg::stat_t out_status;
  clle_pkg::ptr_t  out_node_index;

  clle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_cmd    (in_tdata[2:0]),
    .sts       (sts),
    .in_tready (in_tready),
    .ctl       (ctl)
  );

  clle_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (ctl),
    .in_cmd         (in_tdata[2:0]),
    .in_list_id     (in_tdata[4:3]),
    .in_elem        (in_tdata[12:5]),
    .out_tready     (out_tready),
    .sts            (sts),
    .out_tvalid     (out_tvalid),
    .out_status     (out_status),
    .out_node_index (out_node_index)
  );

  assign out_tdata = {1'b0, out_node_index, out_status};

  // One command at a time: after an accepted transaction the input side closes.
  a_single_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("command accepted while another is in progress");

  // List walk reads of the node memories happen only under a cursor that points at a node.
  a_walk_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.rd_cur |-> sts.walk_ok)
    else $error("list walk read outside the pool or past the walk bound");

  // A full pool never reports an allocated node.
  a_full_no_node: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_status == clle_pkg::ST_FULL) |-> (out_node_index == clle_pkg::NIL))
    else $error("pool full result carries a node index");

endmodule

FILE: bench/cursor_linked_list_engine_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core_tb
// Self-checking bench for the linked list engine: commands are streamed in,
// a behavioral copy of the node pool predicts each status and node index,
// and every result transaction is compared against the oldest prediction.
// ----------------------------------------------------------------------------
module cursor_linked_list_engine_core_tb;

  // Code 7 has no command behind it; the engine must answer it as a no-op.
  localparam clle_pkg::cmd_t CMD_UNUSED = 3'd7;
  localparam int   NO_NODE    = -1;
  // Settle time covers the longest walk, a clear of a full list.
  localparam int   SETTLE_CYC = 3 * clle_pkg::NODES + 16;
  localparam int   HOLD_CYC   = 300;

  typedef struct {
    clle_pkg::stat_t status;
    clle_pkg::ptr_t  node;
  } cmd_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [2:0] cmd, [4:3] list_id, [12:5] elem, [15:13] zero
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;  // [1:0] status, [6:2] node_index, [7] zero

  // Behavioral copy of the pool; links hold NO_NODE for the end of a chain.
  int  link_of [clle_pkg::NODES];
  byte value_of[clle_pkg::NODES];
  int  free_top;
  int  head_of [clle_pkg::LISTS];

  cmd_result_t pending_results[$];
  int          err_cnt;
  bit          gaps_on;
  bit          rx_hold;
  event        rx_hold_ev;

  cursor_linked_list_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // Free-running clock, 10 ns period.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard limit on the run time.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    err_cnt++;
  endtask

  // Put every link, the free list and the heads back to the reset picture.
  function automatic void pool_reset();
    for (int i = 0; i < clle_pkg::NODES; i++) begin
      link_of[i] = i - 1;
    end
    free_top = clle_pkg::NODES - 1;
    for (int i = 0; i < clle_pkg::LISTS; i++) begin
      head_of[i] = NO_NODE;
    end
  endfunction

  // Relink helper: prev == NO_NODE stands for the list head itself.
  function automatic void link_after(input int lst, input int prev, input int node);
    if (prev >= 0) begin
      link_of[prev] = node;
    end else begin
      head_of[lst] = node;
    end
  endfunction

  // Apply one command to the pool copy and queue the result it must produce.
  function automatic void pool_step(input clle_pkg::cmd_t c, input int lst, input byte e);
    clle_pkg::stat_t st;
    int              idx;
    int              prev;
    int              cur;
    int              nx;
    int              steps;
    bit              done;
    cmd_result_t     res;
    st   = clle_pkg::ST_OK;
    idx  = NO_NODE;
    prev = NO_NODE;
    case (c)
      clle_pkg::CMD_INS_FIRST, clle_pkg::CMD_INS_SORTED, clle_pkg::CMD_INS_LAST: begin
        if (free_top < 0) begin
          st = clle_pkg::ST_FULL;
        end else begin
          idx      = free_top;
          free_top = link_of[idx];
          cur      = head_of[lst];
          if (c != clle_pkg::CMD_INS_FIRST) begin
            steps = 0;
            done  = 1'b0;
            while (cur >= 0 && steps < clle_pkg::NODES && !done) begin
              if (c == clle_pkg::CMD_INS_SORTED && value_of[cur] >= e) begin
                done = 1'b1;
              end else begin
                prev = cur;
                cur  = link_of[cur];
                steps++;
              end
            end
          end
          value_of[idx] = e;
          link_of[idx]  = cur;
          link_after(lst, prev, idx);
        end
      end
      clle_pkg::CMD_DEL_FIRST, clle_pkg::CMD_DEL_ALL, clle_pkg::CMD_CLEAR: begin
        cur   = head_of[lst];
        steps = 0;
        done  = 1'b0;
        while (cur >= 0 && steps < clle_pkg::NODES && !done) begin
          nx = link_of[cur];
          if (c == clle_pkg::CMD_CLEAR || value_of[cur] == e) begin
            link_after(lst, prev, nx);
            link_of[cur] = free_top;
            free_top     = cur;
            if (idx == NO_NODE) begin
              idx = cur;
            end
            done = (c == clle_pkg::CMD_DEL_FIRST);
          end else begin
            prev = cur;
          end
          cur = nx;
          steps++;
        end
        if (idx == NO_NODE && c != clle_pkg::CMD_CLEAR) begin
          st = clle_pkg::ST_NOMATCH;
        end
      end
      clle_pkg::CMD_REINIT: begin
        pool_reset();
      end
      default: begin
      end
    endcase
    res.status = st;
    res.node   = clle_pkg::ptr_t'(idx);
    pending_results.push_back(res);
  endfunction

  // Offer one command, with optional random idle cycles, until it is taken.
  task automatic send_cmd(input clle_pkg::cmd_t c, input logic [1:0] lst, input byte e);
    while (gaps_on && $urandom_range(99) < 25) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {3'b000, e, lst, c};
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    pool_step(c, int'(lst) % clle_pkg::LISTS, e);
  endtask

  // Stop offering commands until every predicted result has come back.
  task automatic wait_drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  // Element values cluster on a few hot values so that deletes find matches.
  function automatic byte pick_elem();
    case ($urandom_range(11))
      0:       return -8'sd128;
      1:       return 8'sd127;
      2:       return 8'sd0;
      3:       return -8'sd1;
      4:       return 8'sd1;
      5:       return 8'sd42;
      6:       return -8'sd64;
      7:       return 8'sd5;
      default: return byte'($urandom_range(255));
    endcase
  endfunction

  function automatic clle_pkg::cmd_t pick_insert();
    case ($urandom_range(2))
      0:       return clle_pkg::CMD_INS_FIRST;
      1:       return clle_pkg::CMD_INS_SORTED;
      default: return clle_pkg::CMD_INS_LAST;
    endcase
  endfunction

  // Mostly inserts and deletes; clears and reinit keep the pool moving.
  function automatic clle_pkg::cmd_t pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 55) return pick_insert();
    if (r < 72) return clle_pkg::CMD_DEL_FIRST;
    if (r < 84) return clle_pkg::CMD_DEL_ALL;
    if (r < 92) return clle_pkg::CMD_CLEAR;
    if (r < 96) return clle_pkg::CMD_REINIT;
    return CMD_UNUSED;
  endfunction

  // Result side: check each transaction, then pick the next ready value.
  initial begin
    cmd_result_t exp_res;
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_tvalid && out_tready) begin
        if (pending_results.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with no command pending", out_tdata));
        end else begin
          exp_res = pending_results.pop_front();
          if (out_tdata[1:0] !== exp_res.status) begin
            report_mismatch($sformatf("status got %0d expected %0d",
                                      out_tdata[1:0], exp_res.status));
          end
          if (out_tdata[6:2] !== exp_res.node) begin
            report_mismatch($sformatf("node index got %0d expected %0d",
                                      $signed(out_tdata[6:2]), $signed(exp_res.node)));
          end
        end
      end
      out_tready <= !rx_hold && !(gaps_on && $urandom_range(99) < 25);
    end
  end

  // Long receiver hold-off, counted here so the sender keeps pushing.
  initial begin
    rx_hold = 1'b0;
    forever begin
      @(rx_hold_ev);
      rx_hold <= 1'b1;
      repeat (HOLD_CYC) @(posedge clk);
      rx_hold <= 1'b0;
    end
  end

  // Hand-picked commands: extreme values, every command and each corner case.
  task automatic test_directed();
    send_cmd(clle_pkg::CMD_INS_FIRST,  2'd0, 8'sd127);
    send_cmd(clle_pkg::CMD_INS_FIRST,  2'd0, -8'sd128);
    send_cmd(clle_pkg::CMD_INS_LAST,   2'd0, 8'sd0);
    send_cmd(clle_pkg::CMD_INS_SORTED, 2'd1, 8'sd5);
    send_cmd(clle_pkg::CMD_INS_SORTED, 2'd1, -8'sd128);
    send_cmd(clle_pkg::CMD_INS_SORTED, 2'd1, 8'sd127);
    send_cmd(clle_pkg::CMD_INS_SORTED, 2'd1, 8'sd5);
    send_cmd(clle_pkg::CMD_INS_SORTED, 2'd1, 8'sd0);
    send_cmd(clle_pkg::CMD_INS_LAST,   2'd3, -8'sd1);
    send_cmd(clle_pkg::CMD_INS_LAST,   2'd3, -8'sd1);
    send_cmd(clle_pkg::CMD_INS_FIRST,  2'd3, 8'sd7);
    send_cmd(clle_pkg::CMD_DEL_FIRST,  2'd1, 8'sd5);
    send_cmd(clle_pkg::CMD_DEL_FIRST,  2'd1, 8'sd99);
    send_cmd(clle_pkg::CMD_DEL_ALL,    2'd3, -8'sd1);
    send_cmd(clle_pkg::CMD_DEL_ALL,    2'd2, 8'sd3);
    send_cmd(clle_pkg::CMD_CLEAR,      2'd2, 8'sd0);
    send_cmd(clle_pkg::CMD_CLEAR,      2'd0, -8'sd85);
    send_cmd(CMD_UNUSED,               2'd1, 8'sd85);
    send_cmd(clle_pkg::CMD_INS_SORTED, 2'd1, -8'sd128);
    send_cmd(clle_pkg::CMD_DEL_FIRST,  2'd1, 8'sd127);
    send_cmd(clle_pkg::CMD_REINIT,     2'd3, 8'sd0);
    send_cmd(clle_pkg::CMD_INS_FIRST,  2'd2, 8'sd1);
    send_cmd(clle_pkg::CMD_DEL_ALL,    2'd1, 8'sd0);
  endtask

  // Fill the pool past capacity, then free it again list by list.
  task automatic test_pool_full();
    send_cmd(clle_pkg::CMD_REINIT, 2'($urandom_range(3)), pick_elem());
    for (int i = 0; i < clle_pkg::NODES + 2; i++) begin
      send_cmd(pick_insert(), 2'($urandom_range(3)), pick_elem());
    end
    send_cmd(clle_pkg::CMD_INS_FIRST,  2'd0, pick_elem());
    send_cmd(clle_pkg::CMD_INS_SORTED, 2'd1, pick_elem());
    send_cmd(clle_pkg::CMD_INS_LAST,   2'd2, pick_elem());
    for (int l = 0; l < clle_pkg::LISTS; l++) begin
      send_cmd(clle_pkg::CMD_DEL_ALL, 2'(l), pick_elem());
      send_cmd(clle_pkg::CMD_CLEAR,   2'(l), pick_elem());
    end
  endtask

  // Random command mix, with a long stretch where neither side idles.
  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      gaps_on = !(i >= 250 && i < 400);
      send_cmd(pick_cmd(), 2'($urandom_range(3)), pick_elem());
    end
    gaps_on = 1'b1;
  endtask

  // Receiver stalls for a long time while commands keep coming, then the
  // sender pauses until all results are back; inserts with gaps then drain too.
  task automatic test_backpressure();
    gaps_on = 1'b0;
    -> rx_hold_ev;
    for (int i = 0; i < 10; i++) begin
      send_cmd(pick_cmd(), 2'($urandom_range(3)), pick_elem());
    end
    wait_drain();
    gaps_on = 1'b1;
    for (int i = 0; i < 10; i++) begin
      send_cmd(pick_insert(), 2'($urandom_range(3)), pick_elem());
    end
    wait_drain();
  endtask

  // Reset, run the tests in turn, then settle and judge.
  initial begin
    err_cnt   = 0;
    gaps_on   = 1'b1;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    pool_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_pool_full();
    test_backpressure();
    test_random(620);
    test_backpressure();

    wait_drain();
    repeat (SETTLE_CYC) @(posedge clk);
    if (err_cnt == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
